// File: rtl/core/gasfg_pkg.sv
`default_nettype none

package gasfg_pkg;

   // Fixed-point format of the angle fields.
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int TRACKER_BITS    = 8;
   localparam int QUEUE_DEPTH     = 2;

   // Pi in Q32 and in the angle format, rounded to nearest.
   localparam longint PI_Q32   = 64'sd13493037705;
   localparam longint PI_Q     = (PI_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS)))
                                 >>> (32 - ANGLE_FRAC_BITS);
   localparam longint TWO_PI_Q = 2 * PI_Q;

   // Number of full turns a wrap candidate may be away from an 18 bit value.
   localparam int WRAP_K = int'((64'sd1 <<< 17) / TWO_PI_Q) + 1;

   localparam logic signed [19:0] PI_W = 20'(PI_Q);

   // Radians to 1/128 degree: q * 23040 * 2^(32 - frac) / PI_Q32.
   localparam longint       DEG_SCALE     = 64'sd23040 <<< (32 - ANGLE_FRAC_BITS);
   localparam logic [95:0]  DEG_RECIP_NUM = 96'(DEG_SCALE) << 32;
   localparam logic [31:0]  DEG_RECIP     = 32'(DEG_RECIP_NUM / 96'(PI_Q32));
   localparam logic [47:0]  DEG_ROUND     = 48'(1) << 31;
   localparam logic [51:0]  DEG_K52       = 52'(DEG_SCALE);
   localparam logic [51:0]  DEG_P52       = 52'(PI_Q32);
   localparam logic [51:0]  DEG_H52       = 52'(PI_Q32 / 2);

   // Smoothing weight of one in Q16.
   localparam logic [16:0] ALPHA_ONE = 17'd65536;

   // Configuration register indexes.
   localparam logic [2:0] CSR_YAW_LIMIT     = 3'd0;
   localparam logic [2:0] CSR_PITCH_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_SMOOTH_ALPHA  = 3'd2;
   localparam logic [2:0] CSR_YAW_FIRE_TOL  = 3'd3;
   localparam logic [2:0] CSR_PITCH_FIRE_TOL = 3'd4;

   localparam logic [15:0] YAW_LIMIT_RESET   = 16'd51472;
   localparam logic [14:0] PITCH_LIMIT_RESET = 15'd25736;
   localparam logic [16:0] ALPHA_RESET       = 17'd65536;
   localparam logic [15:0] FIRE_TOL_RESET    = 16'd164;

   typedef struct packed {
      logic [15:0] yaw_limit;
      logic [14:0] pitch_limit;
      logic [16:0] smooth_alpha;
      logic [15:0] yaw_fire_tolerance;
      logic [15:0] pitch_fire_tolerance;
   } cfg_type;

   // One classified command between the front and the back.
   typedef struct packed {
      logic               shot;
      logic signed [16:0] yaw;
      logic signed [15:0] pitch;
      logic [7:0]         tracker;
      logic [15:0]        distance;
      logic               fire_ok;
   } cmd_type;

   // Map an angle into (-pi, pi] by picking the one candidate in range.
   function automatic logic signed [16:0] wrap_angle(input logic signed [17:0] x);
      logic signed [19:0] cand;
      logic signed [16:0] r;
      r = '0;
      for (int k = -WRAP_K; k <= WRAP_K; k++) begin
         cand = 20'(x) - 20'(longint'(k) * TWO_PI_Q);
         if (cand > -PI_W && cand <= PI_W) begin
            r = 17'(cand);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/gasfg_front.sv
`default_nettype none

module gasfg_front (
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic signed [16:0] req_target_yaw,
   input  wire logic signed [15:0] req_target_pitch,
   input  wire logic [7:0]         req_tracker_index,
   input  wire logic [15:0]        req_target_range,
   input  wire logic               req_fire_request,
   input  wire gasfg_pkg::cfg_type cfg,
   input  wire logic               queue_full,
   output logic                    push,
   output gasfg_pkg::cmd_type      cmd
);

   logic signed [17:0] ty_w;
   logic signed [17:0] ylim_w;
   logic signed [16:0] tp_w;
   logic signed [16:0] plim_w;
   logic signed [16:0] ly;
   logic signed [15:0] lp;
   logic               clamped;

   // Accept whenever the queue has room.
   assign req_ready = ~queue_full;
   assign push      = req_valid & ~queue_full;

   // Clamp both angles to their magnitude limits and note any clamping.
   always_comb begin
      ty_w    = 18'(req_target_yaw);
      ylim_w  = $signed({2'b00, cfg.yaw_limit});
      tp_w    = 17'(req_target_pitch);
      plim_w  = $signed({2'b00, cfg.pitch_limit});
      clamped = 1'b0;
      if (ty_w > ylim_w) begin
         ly      = 17'(ylim_w);
         clamped = 1'b1;
      end else if (ty_w < -ylim_w) begin
         ly      = 17'(-ylim_w);
         clamped = 1'b1;
      end else begin
         ly = 17'(ty_w);
      end
      if (tp_w > plim_w) begin
         lp      = 16'(plim_w);
         clamped = 1'b1;
      end else if (tp_w < -plim_w) begin
         lp      = 16'(-plim_w);
         clamped = 1'b1;
      end else begin
         lp = 16'(tp_w);
      end
   end

   // Classify: every command, shot plan or hold, carries its type and its clamped angles.
   always_comb begin
      cmd.shot     = req_type;
      cmd.yaw      = ly;
      cmd.pitch    = lp;
      cmd.tracker  = req_tracker_index;
      cmd.distance = req_target_range;
      cmd.fire_ok  = req_fire_request & ~clamped;
   end

endmodule

`default_nettype wire

// File: rtl/core/gasfg_queue.sv
`default_nettype none

module gasfg_queue #(
   parameter int DEPTH = gasfg_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire gasfg_pkg::cmd_type push_data,
   input  wire logic               pop,
   output gasfg_pkg::cmd_type      head,
   output logic                    empty,
   output logic                    full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gasfg_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; entries are read only after a write.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/gasfg_back.sv
`default_nettype none

module gasfg_back #(
   parameter int TRACKER_BITS = gasfg_pkg::TRACKER_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire gasfg_pkg::cfg_type cfg,
   input  wire logic               queue_empty,
   input  wire gasfg_pkg::cmd_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [16:0]      rsp_yaw_degrees,
   output logic signed [16:0]      rsp_pitch_degrees,
   output logic signed [16:0]      rsp_yaw_radians,
   output logic signed [16:0]      rsp_pitch_radians,
   output logic [15:0]             rsp_distance_out,
   output logic                    rsp_fire_out
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YDIFF,
      ST_YMUL,
      ST_PMUL,
      ST_PUPD,
      ST_LAG,
      ST_DMUL,
      ST_DREM,
      ST_DFIX,
      ST_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic                    filter_valid_ff, filter_valid_in;
   logic [TRACKER_BITS-1:0] last_tracker_ff, last_tracker_in;
   logic signed [16:0]      smooth_yaw_ff, smooth_yaw_in;
   logic signed [16:0]      smooth_pitch_ff, smooth_pitch_in;
   logic signed [16:0]      ly_ff, ly_in;
   logic signed [15:0]      lp_ff, lp_in;
   logic signed [16:0]      cy_ff, cy_in;
   logic signed [16:0]      cp_ff, cp_in;
   logic [15:0]             distance_ff, distance_in;
   logic                    fire_ok_ff, fire_ok_in;
   logic                    fire_ff, fire_in;
   logic signed [16:0]      ydiff_ff, ydiff_in;
   logic signed [35:0]      prod_ff, prod_in;
   logic                    deg_sel_ff, deg_sel_in;
   logic [15:0]             deg_mag_ff, deg_mag_in;
   logic                    deg_neg_ff, deg_neg_in;
   logic [15:0]             qest_ff, qest_in;
   logic signed [51:0]      rem_ff, rem_in;
   logic signed [16:0]      yaw_deg_ff, yaw_deg_in;
   logic signed [16:0]      pitch_deg_ff, pitch_deg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [16:0]      rsp_yaw_deg_ff, rsp_yaw_deg_in;
   logic signed [16:0]      rsp_pitch_deg_ff, rsp_pitch_deg_in;
   logic signed [16:0]      rsp_yaw_rad_ff, rsp_yaw_rad_in;
   logic signed [16:0]      rsp_pitch_rad_ff, rsp_pitch_rad_in;
   logic [15:0]             rsp_distance_ff, rsp_distance_in;
   logic                    rsp_fire_ff, rsp_fire_in;

   logic [TRACKER_BITS-1:0] trk;
   logic [15:0]             alpha16;
   logic signed [17:0]      mul_a;
   logic signed [17:0]      mul_b;
   logic signed [35:0]      mul_p;
   logic signed [17:0]      ema;
   logic signed [16:0]      deg_src;
   logic [15:0]             deg_mag;
   logic [47:0]             deg_prod;
   logic [47:0]             deg_round;
   logic signed [16:0]      yaw_lag;
   logic [16:0]             yaw_lag_abs;
   logic signed [17:0]      pitch_lag;
   logic [17:0]             pitch_lag_abs;
   logic                    lagged;
   logic [16:0]             deg_res;

   assign pop               = (state_ff == ST_IDLE) && !queue_empty;
   assign trk               = TRACKER_BITS'(head.tracker);
   assign alpha16           = cfg.smooth_alpha[15:0];
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_yaw_degrees   = rsp_yaw_deg_ff;
   assign rsp_pitch_degrees = rsp_pitch_deg_ff;
   assign rsp_yaw_radians   = rsp_yaw_rad_ff;
   assign rsp_pitch_radians = rsp_pitch_rad_ff;
   assign rsp_distance_out  = rsp_distance_ff;
   assign rsp_fire_out      = rsp_fire_ff;

   // Shared smoothing multiplier: yaw lag in ST_YMUL, pitch lag in the cycle after.
   always_comb begin
      mul_a = $signed({2'b00, alpha16});
      if (state_ff == ST_YMUL) begin
         mul_b = 18'(ydiff_ff);
      end else begin
         mul_b = 18'(lp_ff) - 18'(smooth_pitch_ff);
      end
      mul_p = mul_a * mul_b;
   end

   // Moving average step rounds half toward plus infinity.
   assign ema = 18'((prod_ff + 36'sd32768) >>> 16);

   // Degree conversion: reciprocal estimate, exact remainder, then correction.
   always_comb begin
      deg_src   = deg_sel_ff ? cp_ff : cy_ff;
      deg_mag   = 16'(deg_src[16] ? -deg_src : deg_src);
      deg_prod  = 48'(deg_mag) * 48'(gasfg_pkg::DEG_RECIP);
      deg_round = deg_prod + gasfg_pkg::DEG_ROUND;
      deg_res   = 17'(qest_ff)
                + 17'(rem_ff >= $signed(gasfg_pkg::DEG_P52))
                - 17'(rem_ff[51]);
   end

   // Lag of the command behind the clamped target.
   always_comb begin
      yaw_lag       = gasfg_pkg::wrap_angle(18'(ly_ff) - 18'(cy_ff));
      yaw_lag_abs   = 17'(yaw_lag[16] ? -yaw_lag : yaw_lag);
      pitch_lag     = 18'(cp_ff) - 18'(lp_ff);
      pitch_lag_abs = 18'(pitch_lag[17] ? -pitch_lag : pitch_lag);
      lagged        = (yaw_lag_abs > {1'b0, cfg.yaw_fire_tolerance})
                    || (pitch_lag_abs > {2'b00, cfg.pitch_fire_tolerance});
   end

   // Sequencer for one command.
   always_comb begin
      state_in         = state_ff;
      filter_valid_in  = filter_valid_ff;
      last_tracker_in  = last_tracker_ff;
      smooth_yaw_in    = smooth_yaw_ff;
      smooth_pitch_in  = smooth_pitch_ff;
      ly_in            = ly_ff;
      lp_in            = lp_ff;
      cy_in            = cy_ff;
      cp_in            = cp_ff;
      distance_in      = distance_ff;
      fire_ok_in       = fire_ok_ff;
      fire_in          = fire_ff;
      ydiff_in         = ydiff_ff;
      prod_in          = prod_ff;
      deg_sel_in       = deg_sel_ff;
      deg_mag_in       = deg_mag_ff;
      deg_neg_in       = deg_neg_ff;
      qest_in          = qest_ff;
      rem_in           = rem_ff;
      yaw_deg_in       = yaw_deg_ff;
      pitch_deg_in     = pitch_deg_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_yaw_deg_in   = rsp_yaw_deg_ff;
      rsp_pitch_deg_in = rsp_pitch_deg_ff;
      rsp_yaw_rad_in   = rsp_yaw_rad_ff;
      rsp_pitch_rad_in = rsp_pitch_rad_ff;
      rsp_distance_in  = rsp_distance_ff;
      rsp_fire_in      = rsp_fire_ff;

      // The output register empties on its transfer.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = ST_LAG;
               if (!head.shot) begin
                  // Hold: zero command, filter restarts.
                  filter_valid_in = 1'b0;
                  last_tracker_in = '0;
                  ly_in           = '0;
                  lp_in           = '0;
                  cy_in           = '0;
                  cp_in           = '0;
                  distance_in     = '0;
                  fire_ok_in      = 1'b0;
               end else begin
                  last_tracker_in = trk;
                  ly_in           = head.yaw;
                  lp_in           = head.pitch;
                  cy_in           = head.yaw;
                  cp_in           = 17'(head.pitch);
                  distance_in     = head.distance;
                  fire_ok_in      = head.fire_ok;
                  if (cfg.smooth_alpha >= gasfg_pkg::ALPHA_ONE) begin
                     filter_valid_in = 1'b0;
                  end else if (!filter_valid_ff || trk != last_tracker_ff) begin
                     // Filter start loads the clamped angles unchanged.
                     smooth_yaw_in   = head.yaw;
                     smooth_pitch_in = 17'(head.pitch);
                     filter_valid_in = 1'b1;
                  end else begin
                     state_in = ST_YDIFF;
                  end
               end
            end
         end
         ST_YDIFF: begin
            ydiff_in = gasfg_pkg::wrap_angle(18'(ly_ff) - 18'(smooth_yaw_ff));
            state_in = ST_YMUL;
         end
         ST_YMUL: begin
            prod_in  = mul_p;
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            smooth_yaw_in = gasfg_pkg::wrap_angle(18'(smooth_yaw_ff) + ema);
            cy_in         = gasfg_pkg::wrap_angle(18'(smooth_yaw_ff) + ema);
            prod_in       = mul_p;
            state_in      = ST_PUPD;
         end
         ST_PUPD: begin
            smooth_pitch_in = 17'(18'(smooth_pitch_ff) + ema);
            cp_in           = 17'(18'(smooth_pitch_ff) + ema);
            state_in        = ST_LAG;
         end
         ST_LAG: begin
            fire_in    = fire_ok_ff & ~lagged;
            deg_sel_in = 1'b0;
            state_in   = ST_DMUL;
         end
         ST_DMUL: begin
            deg_mag_in = deg_mag;
            deg_neg_in = deg_src[16];
            qest_in    = deg_round[47:32];
            state_in   = ST_DREM;
         end
         ST_DREM: begin
            rem_in   = $signed(52'(deg_mag_ff) * gasfg_pkg::DEG_K52
                               + gasfg_pkg::DEG_H52
                               - 52'(qest_ff) * gasfg_pkg::DEG_P52);
            state_in = ST_DFIX;
         end
         ST_DFIX: begin
            if (!deg_sel_ff) begin
               yaw_deg_in = deg_neg_ff ? -$signed(deg_res) : $signed(deg_res);
               deg_sel_in = 1'b1;
               state_in   = ST_DMUL;
            end else begin
               pitch_deg_in = deg_neg_ff ? -$signed(deg_res) : $signed(deg_res);
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_yaw_deg_in   = yaw_deg_ff;
               rsp_pitch_deg_in = pitch_deg_ff;
               rsp_yaw_rad_in   = cy_ff;
               rsp_pitch_rad_in = cp_ff;
               rsp_distance_in  = distance_ff;
               rsp_fire_in      = fire_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         filter_valid_ff <= 1'b0;
         last_tracker_ff <= '0;
         smooth_yaw_ff   <= '0;
         smooth_pitch_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         filter_valid_ff  <= filter_valid_in;
         last_tracker_ff  <= last_tracker_in;
         smooth_yaw_ff    <= smooth_yaw_in;
         smooth_pitch_ff  <= smooth_pitch_in;
         ly_ff            <= ly_in;
         lp_ff            <= lp_in;
         cy_ff            <= cy_in;
         cp_ff            <= cp_in;
         distance_ff      <= distance_in;
         fire_ok_ff       <= fire_ok_in;
         fire_ff          <= fire_in;
         ydiff_ff         <= ydiff_in;
         prod_ff          <= prod_in;
         deg_sel_ff       <= deg_sel_in;
         deg_mag_ff       <= deg_mag_in;
         deg_neg_ff       <= deg_neg_in;
         qest_ff          <= qest_in;
         rem_ff           <= rem_in;
         yaw_deg_ff       <= yaw_deg_in;
         pitch_deg_ff     <= pitch_deg_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_yaw_deg_ff   <= rsp_yaw_deg_in;
         rsp_pitch_deg_ff <= rsp_pitch_deg_in;
         rsp_yaw_rad_ff   <= rsp_yaw_rad_in;
         rsp_pitch_rad_ff <= rsp_pitch_rad_in;
         rsp_distance_ff  <= rsp_distance_in;
         rsp_fire_ff      <= rsp_fire_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/gimbal_angle_smoother_fire_gate.sv
// Channel   Ports              Handshake         Payload
// request   req_*              valid / ready     type, yaw, pitch, tracker, range, fire
// response  rsp_*              valid / ready     degrees, radians, distance, fire
// config    csr_*              write enable      index 0..4, 17 bit data
//
// A command runs the lag check and both degree conversions, after the moving average
// when it runs: the smoothing multiplier is used once per angle, and one reciprocal
// multiplier converts both angles to degrees in turn, by estimate, remainder and correction.
// A two-entry queue lets requests be taken while the back end or the response
// register is stalled. Reset clears the filter and loads register defaults.
`default_nettype none

module gimbal_angle_smoother_fire_gate #(
   parameter int TRACKER_BITS = gasfg_pkg::TRACKER_BITS,
   parameter int QUEUE_DEPTH  = gasfg_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic signed [16:0] req_target_yaw,
   input  wire logic signed [15:0] req_target_pitch,
   input  wire logic [7:0]         req_tracker_index,
   input  wire logic [15:0]        req_target_range,
   input  wire logic               req_fire_request,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [16:0]      rsp_yaw_degrees,
   output logic signed [16:0]      rsp_pitch_degrees,
   output logic signed [16:0]      rsp_yaw_radians,
   output logic signed [16:0]      rsp_pitch_radians,
   output logic [15:0]             rsp_distance_out,
   output logic                    rsp_fire_out,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [16:0]        csr_wdata
);

   gasfg_pkg::cfg_type cfg_ff;
   gasfg_pkg::cfg_type cfg_in;
   gasfg_pkg::cmd_type push_cmd;
   gasfg_pkg::cmd_type head_cmd;
   logic               push;
   logic               pop;
   logic               queue_empty;
   logic               queue_full;

   // Register writes; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            gasfg_pkg::CSR_YAW_LIMIT:      cfg_in.yaw_limit            = csr_wdata[15:0];
            gasfg_pkg::CSR_PITCH_LIMIT:    cfg_in.pitch_limit          = csr_wdata[14:0];
            gasfg_pkg::CSR_SMOOTH_ALPHA:   cfg_in.smooth_alpha         = csr_wdata;
            gasfg_pkg::CSR_YAW_FIRE_TOL:   cfg_in.yaw_fire_tolerance   = csr_wdata[15:0];
            gasfg_pkg::CSR_PITCH_FIRE_TOL: cfg_in.pitch_fire_tolerance = csr_wdata[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_limit            <= gasfg_pkg::YAW_LIMIT_RESET;
         cfg_ff.pitch_limit          <= gasfg_pkg::PITCH_LIMIT_RESET;
         cfg_ff.smooth_alpha         <= gasfg_pkg::ALPHA_RESET;
         cfg_ff.yaw_fire_tolerance   <= gasfg_pkg::FIRE_TOL_RESET;
         cfg_ff.pitch_fire_tolerance <= gasfg_pkg::FIRE_TOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: clamp and classify each request.
   gasfg_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_target_yaw    (req_target_yaw),
      .req_target_pitch  (req_target_pitch),
      .req_tracker_index (req_tracker_index),
      .req_target_range  (req_target_range),
      .req_fire_request  (req_fire_request),
      .cfg               (cfg_ff),
      .queue_full        (queue_full),
      .push              (push),
      .cmd               (push_cmd)
   );

   gasfg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // Back end: filter, fire gate, degree conversion and response register.
   gasfg_back #(
      .TRACKER_BITS (TRACKER_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .queue_empty       (queue_empty),
      .head              (head_cmd),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_yaw_degrees   (rsp_yaw_degrees),
      .rsp_pitch_degrees (rsp_pitch_degrees),
      .rsp_yaw_radians   (rsp_yaw_radians),
      .rsp_pitch_radians (rsp_pitch_radians),
      .rsp_distance_out  (rsp_distance_out),
      .rsp_fire_out      (rsp_fire_out)
   );

endmodule

`default_nettype wire
